@@ hw/rtl/csttok_pkg.sv @@
// Package for the character stream tokenizer: codes, scan modes, character classes, keywords.
`default_nettype none
package csttok_pkg;

   localparam int OFFSET_WIDTH_DEF = 24;
   localparam int LINE_WIDTH_DEF   = 20;
   localparam int COLUMN_WIDTH_DEF = 16;

   localparam int KIND_W    = 5;
   localparam int ERR_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int KW_BUF_W  = 48;
   localparam int KW_MAX    = 6;
   localparam int KW_COUNT  = 8;

   localparam logic [KIND_W-1:0] KIND_END      = 5'd0;
   localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd1;
   localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd2;
   localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd3;
   localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd4;
   localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd5;
   localparam logic [KIND_W-1:0] KIND_COLON    = 5'd6;
   localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd7;
   localparam logic [KIND_W-1:0] KIND_STRING   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd9;
   localparam logic [KIND_W-1:0] KIND_INT      = 5'd10;
   localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd11;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd19;

   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNTERM  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_INT    = 3'd2,
      MODE_STRING = 3'd3,
      MODE_HALT   = 3'd4
   } csttok_mode_type;

   // Write strobes into the result queue: second is only set together with first.
   typedef struct packed {
      logic first;
      logic second;
   } csttok_push_type;

   // Keyword text, right aligned, oldest character in the highest used byte.
   localparam logic [KW_BUF_W-1:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_0000_666E,   // fn
      48'h7265_7475_726E,   // return
      48'h0000_0069_6E74,   // int
      48'h0000_0073_7472,   // str
      48'h0000_766F_6964,   // void
      48'h0000_626F_6F6C,   // bool
      48'h0000_7472_7565,   // true
      48'h0066_616C_7365    // false
   };

   function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_ident_char(input logic [CHAR_W-1:0] c);
      return is_alpha(c) || is_digit(c) || c == CHAR_UNDER;
   endfunction

   // Kind of a punctuation character, or KIND_END where the character is none.
   function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         8'h28: k = KIND_LPAREN;
         8'h29: k = KIND_RPAREN;
         8'h7B: k = KIND_LBRACE;
         8'h7D: k = KIND_RBRACE;
         8'h3B: k = KIND_SEMI;
         8'h3A: k = KIND_COLON;
         8'h2C: k = KIND_COMMA;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

   // Identifier or keyword kind for a closed identifier.
   function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_BUF_W-1:0] buf_text,
                                                    input logic too_long);
      logic [KIND_W-1:0] k;
      k = KIND_IDENT;
      if (!too_long) begin
         for (int i = 0; i < KW_COUNT; i++) begin
            if (buf_text == KW_TEXT[i]) begin
               k = KIND_KEYWORD0 + KIND_W'(i);
            end
         end
      end
      return k;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/char_stream_tokenizer_unit.sv @@
// Top level of the character stream tokenizer: scanner state and result packing.
// The tokens caused by a character are written into the result queue at its transfer.
// Throughput: one item per cycle; a character that ends a word and gives a token or an
// error itself, or an end marker that flushes a word, gives two results, drained one per
// cycle while rsp_tready is high; req_tready drops while more than two results wait.
// Reset: synchronous, active high; scanner to idle at offset 0, line 1, column 0; queue emptied.
`default_nettype none
module char_stream_tokenizer_unit #(
   parameter int OFFSET_WIDTH = csttok_pkg::OFFSET_WIDTH_DEF,
   parameter int LINE_WIDTH   = csttok_pkg::LINE_WIDTH_DEF,
   parameter int COLUMN_WIDTH = csttok_pkg::COLUMN_WIDTH_DEF,
   localparam int FIELDS_W    = csttok_pkg::KIND_W + 2 * OFFSET_WIDTH + LINE_WIDTH
                                + COLUMN_WIDTH + csttok_pkg::ERR_W,
   localparam int RSP_DATA_W  = ((FIELDS_W + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] char_code
   input  wire logic                  req_tuser,   // [0] end_of_input
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // From bit 0 up: token_kind, token_start, token_length, token_line, token_column,
   // error_code, then zero padding to a whole number of bytes.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast    // last_of_run
);
   import csttok_pkg::*;

   typedef struct packed {
      logic [ERR_W-1:0]        err;
      logic [COLUMN_WIDTH-1:0] column;
      logic [LINE_WIDTH-1:0]   line;
      logic [OFFSET_WIDTH-1:0] length;
      logic [OFFSET_WIDTH-1:0] start;
      logic [KIND_W-1:0]       kind;
   } tok_type;

   localparam int ENTRY_W = FIELDS_W + 1;

   // Scanner state.
   csttok_mode_type         mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] position_ff, position_in;
   logic [OFFSET_WIDTH-1:0] pend_start_ff, pend_start_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [COLUMN_WIDTH-1:0] column_ff, column_in;
   logic [LINE_WIDTH-1:0]   pend_line_ff, pend_line_in;
   logic [COLUMN_WIDTH-1:0] pend_column_ff, pend_column_in;
   logic [KW_BUF_W-1:0]     kw_buf_ff, kw_buf_in;
   logic                    too_long_ff, too_long_in;

   logic                    accept;
   logic [CHAR_W-1:0]       c;
   logic                    eoi;
   logic [KIND_W-1:0]       pkind;
   logic                    c_punct;
   logic                    c_quote;
   logic                    c_lf;
   logic                    c_ident_start;
   logic                    c_digit;
   logic                    c_space;
   logic                    in_word;
   logic                    word_ends;
   logic                    go_idle;
   logic                    opens;
   logic [OFFSET_WIDTH-1:0] len_now;

   logic                    flush_v;
   logic                    char_v;
   tok_type                 flush_tok;
   tok_type                 char_tok;
   tok_type                 word_tok;
   tok_type                 idle_tok;
   tok_type                 unterm_tok;

   csttok_push_type         push;
   logic [ENTRY_W-1:0]      din_first;
   logic [ENTRY_W-1:0]      din_second;
   logic [ENTRY_W-1:0]      dout;
   logic                    has_room;
   logic                    pop;

   assign req_tready = has_room;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign c          = req_tdata;
   assign eoi        = req_tuser;

   // Character classes of the incoming byte.
   assign pkind         = punct_kind(c);
   assign c_punct       = pkind != KIND_END;
   assign c_quote       = c == CHAR_QUOTE;
   assign c_lf          = c == CHAR_LF;
   assign c_ident_start = is_alpha(c) || c == CHAR_UNDER;
   assign c_digit       = is_digit(c);
   assign c_space       = is_space(c);

   // An open identifier or integer closes on the first character that cannot extend it;
   // that character is then handled as though the scanner were idle.
   assign in_word   = mode_ff == MODE_IDENT || mode_ff == MODE_INT;
   assign word_ends = (mode_ff == MODE_IDENT && !is_ident_char(c))
                      || (mode_ff == MODE_INT && !c_digit);
   assign go_idle   = !eoi && (mode_ff == MODE_IDLE || word_ends);
   assign opens     = go_idle && (c_quote || c_ident_start || c_digit);
   assign len_now   = position_ff - pend_start_ff;

   // Candidate tokens.
   always_comb begin
      word_tok.kind   = (mode_ff == MODE_IDENT) ? ident_kind(kw_buf_ff, too_long_ff)
                                                : KIND_INT;
      word_tok.start  = pend_start_ff;
      word_tok.length = len_now;
      word_tok.line   = pend_line_ff;
      word_tok.column = pend_column_ff;
      word_tok.err    = ERR_NONE;

      unterm_tok        = word_tok;
      unterm_tok.kind   = KIND_ERROR;
      unterm_tok.err    = ERR_UNTERM;

      idle_tok.kind   = c_punct ? pkind : KIND_ERROR;
      idle_tok.start  = position_ff;
      idle_tok.length = OFFSET_WIDTH'(1);
      idle_tok.line   = line_ff;
      idle_tok.column = column_ff;
      idle_tok.err    = c_punct ? ERR_NONE : ERR_UNKNOWN;
   end

   // Results of the accepted item: an optional flushed word, then an optional token
   // caused by the character or the end marker itself.
   always_comb begin
      flush_v   = 1'b0;
      char_v    = 1'b0;
      flush_tok = word_tok;
      char_tok  = idle_tok;
      if (mode_ff != MODE_HALT) begin
         if (eoi) begin
            flush_v = in_word;
            char_v  = 1'b1;
            if (mode_ff == MODE_STRING) begin
               char_tok = unterm_tok;
            end else begin
               char_tok.kind   = KIND_END;
               char_tok.start  = position_ff;
               char_tok.length = '0;
               char_tok.line   = line_ff;
               char_tok.column = column_ff;
               char_tok.err    = ERR_NONE;
            end
         end else if (mode_ff == MODE_STRING) begin
            if (c_quote) begin
               char_v          = 1'b1;
               char_tok        = word_tok;
               char_tok.kind   = KIND_STRING;
               char_tok.length = len_now + OFFSET_WIDTH'(1);
            end else if (c_lf) begin
               char_v   = 1'b1;
               char_tok = unterm_tok;
            end
         end else if (go_idle) begin
            flush_v = word_ends;
            // Whitespace and characters that open a token give nothing yet.
            char_v  = c_punct || !(c_space || c_quote || c_ident_start || c_digit);
         end
      end
   end

   // Next scan mode.
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         MODE_STRING: begin
            if (eoi || c_lf) begin
               mode_in = MODE_HALT;
            end else if (c_quote) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_IDLE, MODE_IDENT, MODE_INT: begin
            if (eoi) begin
               mode_in = MODE_IDLE;
            end else if (go_idle) begin
               if (c_punct || c_space) begin
                  mode_in = MODE_IDLE;
               end else if (c_quote) begin
                  mode_in = MODE_STRING;
               end else if (c_ident_start) begin
                  mode_in = MODE_IDENT;
               end else if (c_digit) begin
                  mode_in = MODE_INT;
               end else begin
                  mode_in = MODE_HALT;
               end
            end
         end
         default: begin
            mode_in = MODE_HALT;
         end
      endcase
   end

   // Counters, open token location and keyword buffer.
   always_comb begin
      position_in    = position_ff;
      line_in        = line_ff;
      column_in      = column_ff;
      pend_start_in  = pend_start_ff;
      pend_line_in   = pend_line_ff;
      pend_column_in = pend_column_ff;
      kw_buf_in      = kw_buf_ff;
      too_long_in    = too_long_ff;
      if (mode_ff != MODE_HALT && !eoi) begin
         // Offsets, lines and columns stop at their largest value.
         if (position_ff != '1) begin
            position_in = position_ff + OFFSET_WIDTH'(1);
         end
         if (c_lf) begin
            column_in = '0;
            if (line_ff != '1) begin
               line_in = line_ff + LINE_WIDTH'(1);
            end
         end else if (column_ff != '1) begin
            column_in = column_ff + COLUMN_WIDTH'(1);
         end
         if (opens) begin
            pend_start_in  = position_ff;
            pend_line_in   = line_ff;
            pend_column_in = column_ff;
         end
         if (go_idle && c_ident_start) begin
            kw_buf_in   = KW_BUF_W'(c);
            too_long_in = 1'b0;
         end else if (mode_ff == MODE_IDENT && !word_ends) begin
            // Keywords are at most six characters, so longer identifiers stop collecting.
            if (len_now >= OFFSET_WIDTH'(KW_MAX)) begin
               too_long_in = 1'b1;
            end else begin
               kw_buf_in = {kw_buf_ff[KW_BUF_W-CHAR_W-1:0], c};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         position_ff    <= '0;
         pend_start_ff  <= '0;
         line_ff        <= LINE_WIDTH'(1);
         column_ff      <= '0;
         pend_line_ff   <= '0;
         pend_column_ff <= '0;
         kw_buf_ff      <= '0;
         too_long_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         position_ff    <= position_in;
         pend_start_ff  <= pend_start_in;
         line_ff        <= line_in;
         column_ff      <= column_in;
         pend_line_ff   <= pend_line_in;
         pend_column_ff <= pend_column_in;
         kw_buf_ff      <= kw_buf_in;
         too_long_ff    <= too_long_in;
      end
   end

   // The first queue slot takes the flushed word if there is one, else the other token;
   // the final result of the transfer carries the last-of-run flag.
   always_comb begin
      push.first  = accept && (flush_v || char_v);
      push.second = accept && flush_v && char_v;
      if (flush_v) begin
         din_first = {!char_v, flush_tok};
      end else begin
         din_first = {1'b1, char_tok};
      end
      din_second = {1'b1, char_tok};
   end

   csttok_rsp_queue #(
      .ENTRY_W (ENTRY_W)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .din_first  (din_first),
      .din_second (din_second),
      .pop        (pop),
      .dout       (dout),
      .not_empty  (rsp_tvalid),
      .has_room   (has_room)
   );

   assign rsp_tdata = RSP_DATA_W'(dout[FIELDS_W-1:0]);
   assign rsp_tlast = dout[FIELDS_W];

endmodule
`default_nettype wire

@@ hw/rtl/csttok_rsp_queue.sv @@
// Four-entry result queue taking up to two entries and giving one entry per cycle when popped.
`default_nettype none
module csttok_rsp_queue #(
   parameter int ENTRY_W = 92
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire csttok_pkg::csttok_push_type push,
   input  wire logic [ENTRY_W-1:0]      din_first,
   input  wire logic [ENTRY_W-1:0]      din_second,
   input  wire logic                    pop,
   output logic [ENTRY_W-1:0]           dout,
   output logic                         not_empty,
   output logic                         has_room
);
   import csttok_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign not_empty = count_ff != '0;
   assign has_room  = count_ff <= (PTR_W+1)'(DEPTH - 2);
   assign dout      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.first) + PTR_W'(push.second);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W+1)'(push.first) + (PTR_W+1)'(push.second)
                  - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= din_first;
      end
      if (push.second) begin
         mem_ff[wr_next] <= din_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire
